// ----- rtl/sha1h_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types, action codes and SHA-1 round helpers for the byte stream
// hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

    localparam int WORD_W      = 32;
    localparam int DIGEST_W    = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;

    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    function automatic t_word init_word(input logic [2:0] idx);
        t_word v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

    function automatic t_word round_f(input logic [6:0] t, input t_word b,
                                      input t_word c, input t_word d);
        t_word v;
        priority if (t < 7'd20) begin
            v = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            v = b ^ c ^ d;
        end else if (t < 7'd60) begin
            v = (b & c) | (b & d) | (c & d);
        end else begin
            v = b ^ c ^ d;
        end
        return v;
    endfunction

    function automatic t_word round_k(input logic [6:0] t);
        t_word v;
        priority if (t < 7'd20) begin
            v = 32'h5A827999;
        end else if (t < 7'd40) begin
            v = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            v = 32'h8F1BBCDC;
        end else begin
            v = 32'hCA62C1D6;
        end
        return v;
    endfunction

endpackage

// ----- rtl/sha1_byte_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream with on-demand digest of the message so far.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one action per
// transfer: append a byte, finish (emit digest of the bytes so far) or
// restart. Output channel (o_out_valid / i_out_ready / o_out_item) returns
// five digest words per finish, word 0 first, last_word set on word 4.
// Appended bytes are packed into 32-bit words held in a 16-word block RAM.
// An append that fills a block starts a compression (a read-prefetch load,
// 80 rounds, a chaining add), bounded by the single round unit doing one
// round per cycle. A finish compresses one padded block, or two when 56 or
// more bytes are buffered, before the first word appears; it pads a copy of
// the chaining words and leaves the running hash untouched.
// Items are taken one at a time: o_in_ready is low while a block or a digest
// is in progress and while digest words are being handed out. A stalled
// receiver holds the output register and the block waits with it; the last
// word may wait there while the next item is already accepted.
// Reset loads the SHA-1 initial values and empties the buffer and length.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sha1h_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sha1h_pkg::t_out_item o_out_item
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // which padded block is being compressed
    typedef enum logic [1:0] {
        BLK_DATA    = 2'd0,
        BLK_PAD     = 2'd1,
        BLK_PAD_LEN = 2'd2,
        BLK_LEN     = 2'd3
    } t_blk_kind;

    t_state              r_state;
    t_blk_kind           r_kind;
    logic [5:0]          r_fill;
    logic [31:0]         r_count;
    logic [31:0]         r_part;
    logic [6:0]          r_t;
    logic [2:0]          r_idx;
    sha1h_pkg::t_word    r_h    [sha1h_pkg::DIGEST_W];
    sha1h_pkg::t_word    r_d    [sha1h_pkg::DIGEST_W];
    sha1h_pkg::t_word    r_w    [sha1h_pkg::DIGEST_W];
    sha1h_pkg::t_word    r_s    [sha1h_pkg::BLOCK_WORDS];
    logic                r_out_valid;
    sha1h_pkg::t_out_item r_out_item;

    logic                in_xfer;
    logic                ram_we;
    logic [3:0]          ram_waddr;
    sha1h_pkg::t_word    ram_wdata;
    logic [3:0]          ram_raddr;
    sha1h_pkg::t_word    ram_rdata;
    sha1h_pkg::t_word    base   [sha1h_pkg::DIGEST_W];
    sha1h_pkg::t_word    pad_word;
    sha1h_pkg::t_word    msg_word;
    sha1h_pkg::t_word    sched_word;
    sha1h_pkg::t_word    w_cur;
    sha1h_pkg::t_word    round_tmp;
    sha1h_pkg::t_word    len_bits;
    logic [3:0]          wj;
    logic [5:0]          n_fill;
    logic                out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign n_fill     = r_fill + 6'd1;
    assign len_bits   = {r_count[28:0], 3'b000};

    // buffer word write: every fourth appended byte completes a word
    assign ram_we    = in_xfer && (i_in_item.action == sha1h_pkg::ACT_APPEND)
                       && (r_fill[1:0] == 2'd3);
    assign ram_waddr = r_fill[5:2];
    assign ram_wdata = {r_part[31:8], i_in_item.data_byte};
    // prefetch word t+1 while round t runs; word 0 during the load cycle
    assign ram_raddr = (r_state == S_LOAD) ? 4'd0 : (r_t[3:0] + 4'd1);

    sha1h_ram #(
        .WIDTH(sha1h_pkg::WORD_W),
        .DEPTH(sha1h_pkg::BLOCK_WORDS)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
            base[i] = (r_kind == BLK_DATA) ? r_h[i] : r_d[i];
        end
    end

    // word holding the end of the message: buffered bytes, then 0x80
    always_comb begin
        unique case (r_fill[1:0])
            2'd0: pad_word = {sha1h_pkg::PAD_BYTE, 24'h0};
            2'd1: pad_word = {r_part[31:24], sha1h_pkg::PAD_BYTE, 16'h0};
            2'd2: pad_word = {r_part[31:16], sha1h_pkg::PAD_BYTE, 8'h0};
            default: pad_word = {r_part[31:8], sha1h_pkg::PAD_BYTE};
        endcase
    end

    assign wj = r_t[3:0];

    always_comb begin
        unique case (r_kind)
            BLK_DATA: msg_word = ram_rdata;
            BLK_PAD, BLK_PAD_LEN: begin
                priority if (wj < r_fill[5:2]) begin
                    msg_word = ram_rdata;
                end else if (wj == r_fill[5:2]) begin
                    msg_word = pad_word;
                end else if ((r_kind == BLK_PAD_LEN) && (wj == 4'd15)) begin
                    msg_word = len_bits;
                end else begin
                    msg_word = '0;
                end
            end
            default: msg_word = (wj == 4'd15) ? len_bits : '0;
        endcase
    end

    always_comb begin
        sched_word = r_s[13] ^ r_s[8] ^ r_s[2] ^ r_s[0];
        sched_word = {sched_word[30:0], sched_word[31]};
        w_cur      = (r_t < 7'd16) ? msg_word : sched_word;
        round_tmp  = {r_w[0][26:0], r_w[0][31:27]}
                     + sha1h_pkg::round_f(r_t, r_w[1], r_w[2], r_w[3])
                     + r_w[4] + w_cur + sha1h_pkg::round_k(r_t);
    end

    // control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= BLK_DATA;
            r_fill      <= '0;
            r_count     <= '0;
            r_t         <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
                r_h[i] <= sha1h_pkg::init_word(3'(i));
            end
        end else begin
            // drop the word once taken, unless the next one replaces it
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_in_item.action)
                            sha1h_pkg::ACT_APPEND: begin
                                r_fill  <= n_fill;
                                r_count <= r_count + 32'd1;
                                if (r_fill == 6'd63) begin
                                    r_kind  <= BLK_DATA;
                                    r_state <= S_LOAD;
                                end
                            end
                            sha1h_pkg::ACT_FINISH: begin
                                r_kind  <= (r_fill >= 6'd56) ? BLK_PAD : BLK_PAD_LEN;
                                r_state <= S_LOAD;
                            end
                            sha1h_pkg::ACT_RESTART: begin
                                r_fill  <= '0;
                                r_count <= '0;
                                for (int i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
                                    r_h[i] <= sha1h_pkg::init_word(3'(i));
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_t     <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_t <= r_t + 7'd1;
                    if (r_t == 7'(sha1h_pkg::ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    unique case (r_kind)
                        BLK_DATA: r_state <= S_IDLE;
                        BLK_PAD: begin
                            r_kind  <= BLK_LEN;
                            r_state <= S_LOAD;
                        end
                        default: begin
                            r_idx   <= '0;
                            r_state <= S_EMIT;
                        end
                    endcase
                    if (r_kind == BLK_DATA) begin
                        for (int i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
                            r_h[i] <= base[i] + r_w[i];
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_idx       <= r_idx + 3'd1;
                        if (r_idx == 3'(sha1h_pkg::DIGEST_W - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in_item.action == sha1h_pkg::ACT_APPEND)) begin
            unique case (r_fill[1:0])
                2'd0: r_part[31:24] <= i_in_item.data_byte;
                2'd1: r_part[23:16] <= i_in_item.data_byte;
                2'd2: r_part[15:8]  <= i_in_item.data_byte;
                default: r_part[7:0] <= i_in_item.data_byte;
            endcase
        end
        // snapshot the chaining words so the running hash stays intact
        if (in_xfer && (i_in_item.action == sha1h_pkg::ACT_FINISH)) begin
            for (int i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
                r_d[i] <= r_h[i];
            end
        end
        if ((r_state == S_ADD) && (r_kind != BLK_DATA)) begin
            for (int i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
                r_d[i] <= base[i] + r_w[i];
            end
        end
        if (r_state == S_LOAD) begin
            for (int i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
                r_w[i] <= base[i];
            end
        end
        if (r_state == S_ROUND) begin
            r_w[4] <= r_w[3];
            r_w[3] <= r_w[2];
            r_w[2] <= {r_w[1][1:0], r_w[1][31:2]};
            r_w[1] <= r_w[0];
            r_w[0] <= round_tmp;
            for (int i = 0; i < sha1h_pkg::BLOCK_WORDS - 1; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[sha1h_pkg::BLOCK_WORDS-1] <= w_cur;
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_item.digest_word <= r_d[r_idx];
            r_out_item.word_index  <= r_idx;
            r_out_item.last_word   <= (r_idx == 3'(sha1h_pkg::DIGEST_W - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    property p_one_hot_state;
        @(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state);
    endproperty
    a_one_hot_state: assert property (p_one_hot_state)
        else $error("state register lost its one-hot code");

    property p_round_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_ROUND) |-> (r_t < 7'(sha1h_pkg::ROUNDS));
    endproperty
    a_round_bound: assert property (p_round_bound)
        else $error("round counter ran past the last round");

    property p_block_empty_on_compress;
        @(posedge i_clk) disable iff (!i_rst_n)
            ((r_state == S_LOAD) && (r_kind == BLK_DATA)) |-> (r_fill == 6'd0);
    endproperty
    a_block_empty_on_compress: assert property (p_block_empty_on_compress)
        else $error("data block compressed with a partly filled buffer");

    property p_finish_snapshot;
        @(posedge i_clk) disable iff (!i_rst_n)
            (in_xfer && (i_in_item.action == sha1h_pkg::ACT_FINISH))
            |=> (r_state == S_LOAD) && (r_d[0] == $past(r_h[0]))
                && (r_h[4] == $past(r_h[4]));
    endproperty
    a_finish_snapshot: assert property (p_finish_snapshot)
        else $error("finish did not snapshot the chaining words");

    property p_last_word_flag;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_out_valid |-> (r_out_item.last_word == (r_out_item.word_index == 3'd4));
    endproperty
    a_last_word_flag: assert property (p_last_word_flag)
        else $error("last_word does not match the word index");

endmodule

// ----- rtl/sha1h_ram.sv -----
// ----------------------------------------------------------------------------
// sha1h_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sha1h_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SHA-1 byte stream hasher.
// Sends append, finish, restart and unused-action transfers with random gaps and receiver
// stalls. A local SHA-1 predictor works out the digest of every finish, and
// each output transfer is checked field by field against the oldest
// predicted word.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0]   ACT_UNUSED     = 2'd3;
    localparam int           BLOCK_BYTES    = 64;
    localparam int           LEN_ROOM       = 9;
    localparam int           IDLE_PCT       = 26;
    localparam int           TOTAL_ITEMS    = 430;
    localparam int           WATCHDOG_LIMIT = 3000;
    localparam int           DRAIN_CYCLES   = 400;
    localparam int           LONG_HOLD      = 500;
    localparam logic [159:0] SHA1_IV        = {32'h67452301, 32'hEFCDAB89,
                                               32'h98BADCFE, 32'h10325476,
                                               32'hC3D2E1F0};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    sha1h_pkg::t_in_item  in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    sha1h_pkg::t_out_item out_item;

    // predictor state
    logic [159:0]         hash_chain    = SHA1_IV;
    logic [511:0]         pending_block = '0;
    int                   pending_fill  = 0;
    logic [31:0]          message_len   = '0;
    sha1h_pkg::t_out_item expected_words[$];

    // stimulus controls and run statistics
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    int rx_hold_left = 0;
    int idle_run     = 0;
    int mismatches   = 0;
    int items_sent   = 0;
    int finishes     = 0;
    int restarts     = 0;
    int full_blocks  = 0;
    int spill_blocks = 0;
    int ignored      = 0;
    int words_seen   = 0;

    sha1_byte_stream_hasher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One 80-round compression of a big-endian 64-byte block into h_in.
    function automatic logic [159:0] sha1_compress(input logic [159:0] h_in,
                                                   input logic [511:0] blk);
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = blk[511-32*t -: 32];
        end
        {a, b, c, d, e} = h_in;
        for (t = 0; t < 80; t++) begin
            if (t >= 16) begin
                wt = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
                wt = {wt[30:0], wt[31]};
                w[t & 15] = wt;
            end else begin
                wt = w[t];
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            sum = {a[26:0], a[31:27]} + f + e + wt + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        return {h_in[159:128] + a, h_in[127:96] + b, h_in[95:64] + c,
                h_in[63:32] + d, h_in[31:0] + e};
    endfunction

    // Advance the predictor by one accepted transfer.
    task automatic predict_action(input sha1h_pkg::t_in_item item);
        logic [511:0]         pad;
        logic [159:0]         h;
        sha1h_pkg::t_out_item word;
        int                   n;
        int                   i;
        case (item.action)
            sha1h_pkg::ACT_APPEND: begin
                pending_block[511-8*pending_fill -: 8] = item.data_byte;
                pending_fill++;
                message_len++;
                items_sent++;
                if (pending_fill == BLOCK_BYTES) begin
                    hash_chain = sha1_compress(hash_chain, pending_block);
                    pending_fill = 0;
                    full_blocks++;
                end
            end
            sha1h_pkg::ACT_RESTART: begin
                hash_chain = SHA1_IV;
                pending_fill = 0;
                message_len = '0;
                items_sent++;
                restarts++;
            end
            sha1h_pkg::ACT_FINISH: begin
                n = pending_fill;
                pad = pending_block;
                pad[511-8*n -: 8] = sha1h_pkg::PAD_BYTE;
                for (i = n + 1; i < BLOCK_BYTES; i++) begin
                    pad[511-8*i -: 8] = 8'h00;
                end
                h = hash_chain;
                // no room for the length: spill into an extra block
                if (BLOCK_BYTES - n < LEN_ROOM) begin
                    h = sha1_compress(h, pad);
                    pad = '0;
                    spill_blocks++;
                end
                pad[31:0] = message_len << 3;
                h = sha1_compress(h, pad);
                for (i = 0; i < sha1h_pkg::DIGEST_W; i++) begin
                    word.digest_word = h[159-32*i -: 32];
                    word.word_index  = 3'(i);
                    word.last_word   = (i == sha1h_pkg::DIGEST_W - 1);
                    expected_words.push_back(word);
                end
                items_sent++;
                finishes++;
            end
            default: begin
                ignored++;
            end
        endcase
    endtask

    task automatic send_item(input logic [1:0] act, input logic [7:0] value);
        sha1h_pkg::t_in_item item;
        item.action    = act;
        item.data_byte = value;
        if (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        predict_action(item);
    endtask

    task automatic send_bytes(input int count);
        repeat (count) send_item(sha1h_pkg::ACT_APPEND, 8'($urandom_range(255)));
    endtask

    // Hold the input side idle until every predicted word has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    task automatic test_basic_actions();
        send_item(ACT_UNUSED, 8'hA5);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_item(sha1h_pkg::ACT_APPEND, 8'h00);
        send_item(sha1h_pkg::ACT_APPEND, 8'hFF);
        send_item(sha1h_pkg::ACT_APPEND, 8'h61);
        send_item(sha1h_pkg::ACT_FINISH, 8'hFF);
        send_item(ACT_UNUSED, 8'h5A);
        send_item(sha1h_pkg::ACT_FINISH, 8'h3C);
        send_item(sha1h_pkg::ACT_APPEND, 8'h80);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_item(sha1h_pkg::ACT_RESTART, 8'hFF);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_item(sha1h_pkg::ACT_APPEND, 8'h61);
        send_item(sha1h_pkg::ACT_APPEND, 8'h62);
        send_item(sha1h_pkg::ACT_APPEND, 8'h63);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
    endtask

    // Walk the fill level across the padding boundaries, no idling anywhere.
    task automatic test_padding_boundaries();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_item(sha1h_pkg::ACT_RESTART, 8'h00);
        send_bytes(55);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_bytes(1);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_bytes(7);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_bytes(1);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_bytes(1);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering.
    task automatic test_output_stall();
        drain_results();
        rx_hold_left = LONG_HOLD;
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_bytes(12);
        send_item(sha1h_pkg::ACT_FINISH, 8'h00);
        send_bytes(4);
        drain_results();
    endtask

    task automatic test_random_messages();
        int pick;
        int burst;
        while (items_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                if ($urandom_range(99) < 20) begin
                    send_item(sha1h_pkg::ACT_RESTART, 8'($urandom_range(255)));
                end
                burst = ($urandom_range(5) == 0) ? $urandom_range(130, 40)
                                                 : $urandom_range(20);
                send_bytes(burst);
                send_item(sha1h_pkg::ACT_FINISH, 8'($urandom_range(255)));
            end else if (pick < 92) begin
                send_item(ACT_UNUSED, 8'($urandom_range(255)));
            end else if (pick < 96) begin
                send_item(sha1h_pkg::ACT_RESTART, 8'($urandom_range(255)));
            end else begin
                send_item(sha1h_pkg::ACT_FINISH, 8'($urandom_range(255)));
            end
        end
    endtask

    always @(posedge clk) begin
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            out_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        sha1h_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                $display("%0t tb: unexpected digest word %h", $time, out_item);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (out_item.digest_word !== want.digest_word) begin
                    $display("%0t tb: digest_word expected %h got %h",
                             $time, want.digest_word, out_item.digest_word);
                    mismatches++;
                end
                if (out_item.word_index !== want.word_index) begin
                    $display("%0t tb: word_index expected %0d got %0d",
                             $time, want.word_index, out_item.word_index);
                    mismatches++;
                end
                if (out_item.last_word !== want.last_word) begin
                    $display("%0t tb: last_word expected %b got %b",
                             $time, want.last_word, out_item.last_word);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles without any transfer on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("%0t tb: no transfer for %0d cycles, %0d words outstanding",
                     $time, idle_run, expected_words.size());
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_actions();
        test_padding_boundaries();
        test_output_stall();
        test_random_messages();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d transfers, %0d finishes, %0d restarts, %0d ignored actions",
                 items_sent, finishes, restarts, ignored);
        $display("tb: %0d full blocks, %0d padding spills, %0d digest words checked",
                 full_blocks, spill_blocks, words_seen);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
